>>> rtl/jlsd_pkg.sv
package jlsd_pkg;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] forward_accel;
  } jlsd_in_t;

  typedef struct packed {
    logic [23:0] distance;
    logic        status;
  } jlsd_out_t;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BRAKING_DECEL    = 8'd0,
    REG_MAX_ACCEL        = 8'd1,
    REG_MAX_JERK         = 8'd2,
    REG_REACTION_LATENCY = 8'd3
  } jlsd_reg_e;

  localparam logic [15:0] BrakingDecelRst    = 16'd1280;
  localparam logic [15:0] MaxAccelRst        = 16'd1280;
  localparam logic [15:0] MaxJerkRst         = 16'd5120;
  localparam logic [15:0] ReactionLatencyRst = 16'd410;

  localparam logic [23:0] DistMax = 24'hFF_FFFF;

  localparam int unsigned SqrtBits  = 22;
  localparam int unsigned QuotBits  = 50;
  localparam int unsigned NumStages = 87;

endpackage

>>> rtl/jerk_limited_stopping_distance.sv
// Jerk-limited stopping distance. One request per cycle, unless the result side stalls, enters
// a fixed pipeline of 87 register stages, and results leave in order, one per cycle while not
// stalled. Most stages belong to the 22-stage bit-per-stage square root and the 50-stage
// bit-per-stage restoring divider; the rest are multiply and add stages. A stall on the result
// side freezes the whole pipeline, which then stalls the request side in the same cycle.
// Configuration writes are always taken (ready is tied high) and must only be issued while the
// pipeline holds no request.
module jerk_limited_stopping_distance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  jlsd_pkg::jlsd_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output jlsd_pkg::jlsd_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jlsd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [jlsd_pkg::CfgDataW-1:0]       cfg_data_i
);
  import jlsd_pkg::*;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic [14:0] sp;
    logic [15:0] a;
  } st1_t;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic [14:0] sp;
    logic [15:0] a;
    logic [30:0] sl;
    logic [31:0] al;
    logic [31:0] ll;
    logic [31:0] aa;
    logic [31:0] adec;
    logic [31:0] jsq;
    logic [31:0] dsq0;
    logic [16:0] ad;
  } st2_t;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic [15:0] a;
    logic [31:0] aa;
    logic [31:0] adec;
    logic [31:0] dsq0;
    logic [48:0] react;
    logic [32:0] w;
    logic [32:0] dad;
    logic [34:0] div1;
    logic [47:0] jd;
  } st3_t;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic [15:0] a;
    logic [31:0] aa;
    logic [31:0] adec;
    logic [31:0] dsq0;
    logic [48:0] react;
    logic [48:0] jw;
    logic [32:0] dad;
    logic [34:0] div1;
    logic [52:0] div2;
  } st4_t;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic [15:0] a;
    logic [48:0] react;
    logic [32:0] dad;
    logic [34:0] div1;
    logic [52:0] div2;
    logic [50:0] k;
    logic [43:0] dsq;
    logic [52:0] b;
  } st5_t;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic [15:0] a;
    logic [48:0] react;
    logic [32:0] dad;
    logic [34:0] div1;
    logic [52:0] div2;
    logic        br;
    logic [43:0] k44;
    logic [50:0] ex;
    logic [52:0] bc;
  } st6_t;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic [15:0] a;
    logic [48:0] react;
    logic [34:0] div1;
    logic [52:0] div2;
    logic        br;
    logic [43:0] k44;
    logic [51:0] hh;
    logic [50:0] hl;
    logic [49:0] ll;
    logic [59:0] ph;
    logic [58:0] pl;
  } st7_t;

  typedef struct packed {
    logic         inv;
    logic         zro;
    logic [15:0]  a;
    logic [48:0]  react;
    logic [34:0]  div1;
    logic [52:0]  div2;
    logic         br;
    logic [43:0]  k44;
    logic [101:0] sq;
    logic [85:0]  pm;
  } st8_t;

  // what travels alongside the square root
  typedef struct packed {
    logic         inv;
    logic         zro;
    logic         br;
    logic [15:0]  a;
    logic [48:0]  react;
    logic [34:0]  div1;
    logic [52:0]  div2;
    logic [105:0] num2;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic [43:0] x;
    logic [24:0] rem;
    logic [21:0] root;
  } sqs_t;

  typedef struct packed {
    carry_t      c;
    logic [22:0] s;
    logic [22:0] u;
  } t1_t;

  typedef struct packed {
    carry_t      c;
    logic [45:0] ss;
    logic [22:0] u;
  } t2_t;

  typedef struct packed {
    carry_t      c;
    logic [45:0] ph;
    logic [45:0] pl;
  } t3_t;

  typedef struct packed {
    logic         inv;
    logic         zro;
    logic [48:0]  react;
    logic [105:0] n;
    logic [52:0]  dv;
  } t4_t;

  typedef struct packed {
    logic        inv;
    logic        zro;
    logic        sat;
    logic [48:0] react;
    logic [49:0] nlo;
    logic [52:0] rem;
    logic [52:0] dv;
    logic [49:0] q;
  } dvs_t;

  logic [15:0] braking_decel_q, max_accel_q, max_jerk_q, reaction_latency_q;

  logic                 en;
  logic [NumStages-1:0] vld_q;

  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  st4_t s4_d, s4_q;
  st5_t s5_d, s5_q;
  st6_t s6_d, s6_q;
  st7_t s7_d, s7_q;
  st8_t s8_d, s8_q;
  sqs_t sqs_d [SqrtBits+1];
  sqs_t sqs_q [SqrtBits+1];
  t1_t  t1_d, t1_q;
  t2_t  t2_d, t2_q;
  t3_t  t3_d, t3_q;
  t4_t  t4_d, t4_q;
  dvs_t dvs_d [QuotBits+1];
  dvs_t dvs_q [QuotBits+1];
  jlsd_out_t out_d, out_q;

  logic [15:0]  fa_pos;
  logic [75:0]  num1;
  logic [50:0]  tot;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      braking_decel_q    <= BrakingDecelRst;
      max_accel_q        <= MaxAccelRst;
      max_jerk_q         <= MaxJerkRst;
      reaction_latency_q <= ReactionLatencyRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BRAKING_DECEL:    braking_decel_q    <= cfg_data_i;
        REG_MAX_ACCEL:        max_accel_q        <= cfg_data_i;
        REG_MAX_JERK:         max_jerk_q         <= cfg_data_i;
        REG_REACTION_LATENCY: reaction_latency_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the finished result is held back
  assign en         = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // stage 1: checks and acceleration clamp
  always_comb begin
    fa_pos  = {1'b0, in_data_i.forward_accel[14:0]};
    s1_d.inv = (braking_decel_q == '0) || (max_accel_q == '0) || (max_jerk_q == '0) ||
               in_data_i.speed[15];
    s1_d.zro = (in_data_i.speed == '0);
    s1_d.sp  = in_data_i.speed[14:0];
    if (in_data_i.forward_accel[15]) begin
      s1_d.a = '0;
    end else if (fa_pos > max_accel_q) begin
      s1_d.a = max_accel_q;
    end else begin
      s1_d.a = fa_pos;
    end
  end

  // stage 2: base products
  always_comb begin
    s2_d.inv  = s1_q.inv;
    s2_d.zro  = s1_q.zro;
    s2_d.sp   = s1_q.sp;
    s2_d.a    = s1_q.a;
    s2_d.sl   = 31'(s1_q.sp) * 31'(reaction_latency_q);
    s2_d.al   = 32'(s1_q.a) * 32'(reaction_latency_q);
    s2_d.ll   = 32'(reaction_latency_q) * 32'(reaction_latency_q);
    s2_d.aa   = 32'(s1_q.a) * 32'(s1_q.a);
    s2_d.adec = 32'(s1_q.a) * 32'(braking_decel_q);
    s2_d.jsq  = 32'(max_jerk_q) * 32'(max_jerk_q);
    s2_d.dsq0 = 32'(braking_decel_q) * 32'(braking_decel_q);
    s2_d.ad   = 17'(s1_q.a) + 17'(braking_decel_q);
  end

  // stage 3: reaction travel, speed after reaction, divisor products
  always_comb begin
    s3_d.inv   = s2_q.inv;
    s3_d.zro   = s2_q.zro;
    s3_d.a     = s2_q.a;
    s3_d.aa    = s2_q.aa;
    s3_d.adec  = s2_q.adec;
    s3_d.dsq0  = s2_q.dsq0;
    s3_d.react = (49'(s2_q.sl) << 13) + 49'(s2_q.a) * 49'(s2_q.ll);
    s3_d.w     = (33'(s2_q.sp) << 12) + 33'(s2_q.al);
    s3_d.dad   = 33'(braking_decel_q) * 33'(s2_q.ad);
    s3_d.div1  = (35'(s2_q.jsq) << 2) + (35'(s2_q.jsq) << 1);
    s3_d.jd    = 48'(s2_q.jsq) * 48'(braking_decel_q);
  end

  // stage 4: jerk times speed
  always_comb begin
    s4_d.inv   = s3_q.inv;
    s4_d.zro   = s3_q.zro;
    s4_d.a     = s3_q.a;
    s4_d.aa    = s3_q.aa;
    s4_d.adec  = s3_q.adec;
    s4_d.dsq0  = s3_q.dsq0;
    s4_d.react = s3_q.react;
    s4_d.jw    = 49'(max_jerk_q) * 49'(s3_q.w);
    s4_d.dad   = s3_q.dad;
    s4_d.div1  = s3_q.div1;
    s4_d.div2  = (53'(s3_q.jd) << 4) + (53'(s3_q.jd) << 3);
  end

  // stage 5: ramp discriminant and full-ramp term
  always_comb begin
    s5_d.inv   = s4_q.inv;
    s5_d.zro   = s4_q.zro;
    s5_d.a     = s4_q.a;
    s5_d.react = s4_q.react;
    s5_d.dad   = s4_q.dad;
    s5_d.div1  = s4_q.div1;
    s5_d.div2  = s4_q.div2;
    s5_d.k     = (51'(s4_q.jw) << 1) + (51'(s4_q.aa) << 12);
    s5_d.dsq   = {s4_q.dsq0, 12'b0};
    s5_d.b     = (53'(s4_q.jw) << 2) + (53'(s4_q.jw) << 1) +
                 (((53'(s4_q.aa) << 1) + 53'(s4_q.adec)) << 12);
  end

  // stage 6: pick the case, excess over full braking
  always_comb begin
    s6_d.inv   = s5_q.inv;
    s6_d.zro   = s5_q.zro;
    s6_d.a     = s5_q.a;
    s6_d.react = s5_q.react;
    s6_d.dad   = s5_q.dad;
    s6_d.div1  = s5_q.div1;
    s6_d.div2  = s5_q.div2;
    s6_d.br    = (s5_q.k <= 51'(s5_q.dsq));
    s6_d.k44   = s5_q.k[43:0];
    s6_d.ex    = s5_q.k - 51'(s5_q.dsq);
    s6_d.bc    = (s5_q.b > 53'(s5_q.dsq)) ? s5_q.b - 53'(s5_q.dsq) : '0;
  end

  // stage 7: partial products of the full-ramp numerator
  always_comb begin
    s7_d.inv   = s6_q.inv;
    s7_d.zro   = s6_q.zro;
    s7_d.a     = s6_q.a;
    s7_d.react = s6_q.react;
    s7_d.div1  = s6_q.div1;
    s7_d.div2  = s6_q.div2;
    s7_d.br    = s6_q.br;
    s7_d.k44   = s6_q.k44;
    s7_d.hh    = 52'(s6_q.ex[50:25]) * 52'(s6_q.ex[50:25]);
    s7_d.hl    = 51'(s6_q.ex[50:25]) * 51'(s6_q.ex[24:0]);
    s7_d.ll    = 50'(s6_q.ex[24:0]) * 50'(s6_q.ex[24:0]);
    s7_d.ph    = 60'(s6_q.dad) * 60'(s6_q.bc[52:26]);
    s7_d.pl    = 59'(s6_q.dad) * 59'(s6_q.bc[25:0]);
  end

  // stage 8: recombine
  always_comb begin
    s8_d.inv   = s7_q.inv;
    s8_d.zro   = s7_q.zro;
    s8_d.a     = s7_q.a;
    s8_d.react = s7_q.react;
    s8_d.div1  = s7_q.div1;
    s8_d.div2  = s7_q.div2;
    s8_d.br    = s7_q.br;
    s8_d.k44   = s7_q.k44;
    s8_d.sq    = (102'(s7_q.hh) << 50) + (102'(s7_q.hl) << 26) + 102'(s7_q.ll);
    s8_d.pm    = (86'(s7_q.ph) << 26) + 86'(s7_q.pl);
  end

  // stage 9: full-ramp numerator, square root seeded
  always_comb begin
    sqs_d[0].c.inv   = s8_q.inv;
    sqs_d[0].c.zro   = s8_q.zro;
    sqs_d[0].c.br    = s8_q.br;
    sqs_d[0].c.a     = s8_q.a;
    sqs_d[0].c.react = s8_q.react;
    sqs_d[0].c.div1  = s8_q.div1;
    sqs_d[0].c.div2  = s8_q.div2;
    sqs_d[0].c.num2  = (106'(s8_q.pm) << 15) + (106'(s8_q.sq) << 2) + (106'(s8_q.sq) << 1);
    sqs_d[0].x       = s8_q.k44;
    sqs_d[0].rem     = '0;
    sqs_d[0].root    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      s3_q     <= s3_d;
      s4_q     <= s4_d;
      s5_q     <= s5_d;
      s6_q     <= s6_d;
      s7_q     <= s7_d;
      s8_q     <= s8_d;
      sqs_q[0] <= sqs_d[0];
    end
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SqrtBits; j++) begin : g_sqrt
    localparam int unsigned Bit = SqrtBits - 1 - j;
    logic [24:0] rem_sh;
    logic [24:0] trial;

    always_comb begin
      rem_sh = {sqs_q[j].rem[22:0], sqs_q[j].x[2*Bit+1 -: 2]};
      trial  = {1'b0, sqs_q[j].root, 2'b01};
      sqs_d[j+1]   = sqs_q[j];
      if (rem_sh >= trial) begin
        sqs_d[j+1].rem  = rem_sh - trial;
        sqs_d[j+1].root = {sqs_q[j].root[20:0], 1'b1};
      end else begin
        sqs_d[j+1].rem  = rem_sh;
        sqs_d[j+1].root = {sqs_q[j].root[20:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqs_q[j+1] <= sqs_d[j+1];
      end
    end
  end

  // ramp-stop numerator (a + R)^2 * (2R - a)
  always_comb begin
    t1_d.c = sqs_q[SqrtBits].c;
    t1_d.s = (23'(sqs_q[SqrtBits].c.a) << 6) + 23'(sqs_q[SqrtBits].root);
    t1_d.u = (23'(sqs_q[SqrtBits].root) << 1) - (23'(sqs_q[SqrtBits].c.a) << 6);

    t2_d.c  = t1_q.c;
    t2_d.ss = 46'(t1_q.s) * 46'(t1_q.s);
    t2_d.u  = t1_q.u;

    t3_d.c  = t2_q.c;
    t3_d.ph = 46'(t2_q.ss[45:23]) * 46'(t2_q.u);
    t3_d.pl = 46'(t2_q.ss[22:0]) * 46'(t2_q.u);

    num1       = ((76'(t3_q.ph) << 23) + 76'(t3_q.pl)) << 7;
    t4_d.inv   = t3_q.c.inv;
    t4_d.zro   = t3_q.c.zro;
    t4_d.react = t3_q.c.react;
    t4_d.n     = t3_q.c.br ? 106'(num1) : t3_q.c.num2;
    t4_d.dv    = t3_q.c.br ? 53'(t3_q.c.div1) : t3_q.c.div2;

    // quotient of 2^50 or more saturates the distance, unless the speed is zero
    dvs_d[0].inv   = t4_q.inv;
    dvs_d[0].zro   = t4_q.zro;
    dvs_d[0].sat   = (t4_q.n >= 106'({t4_q.dv, 50'b0}));
    dvs_d[0].react = t4_q.react;
    dvs_d[0].nlo   = t4_q.n[49:0];
    dvs_d[0].rem   = t4_q.n[102:50];
    dvs_d[0].dv    = t4_q.dv;
    dvs_d[0].q     = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q     <= t1_d;
      t2_q     <= t2_d;
      t3_q     <= t3_d;
      t4_q     <= t4_d;
      dvs_q[0] <= dvs_d[0];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QuotBits; j++) begin : g_div
    localparam int unsigned Bit = QuotBits - 1 - j;
    logic [53:0] rem_sh;
    logic [53:0] diff;

    always_comb begin
      rem_sh = {dvs_q[j].rem, dvs_q[j].nlo[Bit]};
      diff   = rem_sh - {1'b0, dvs_q[j].dv};
      dvs_d[j+1] = dvs_q[j];
      if (rem_sh >= {1'b0, dvs_q[j].dv}) begin
        dvs_d[j+1].rem    = diff[52:0];
        dvs_d[j+1].q[Bit] = 1'b1;
      end else begin
        dvs_d[j+1].rem    = rem_sh[52:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dvs_q[j+1] <= dvs_d[j+1];
      end
    end
  end

  // final sum, floor to Q16.8 and saturate
  always_comb begin
    tot = 51'(dvs_q[QuotBits].q) + 51'(dvs_q[QuotBits].react);
    out_d.status = dvs_q[QuotBits].inv;
    if (dvs_q[QuotBits].inv) begin
      out_d.distance = DistMax;
    end else if (dvs_q[QuotBits].zro) begin
      out_d.distance = '0;
    end else if (dvs_q[QuotBits].sat || (tot[50:49] != 2'b00)) begin
      out_d.distance = DistMax;
    end else begin
      out_d.distance = tot[48:25];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign out_data_o  = out_q;

endmodule

>>> verif/stopping_distance_checker.sv
`timescale 1ns / 1ps

module stopping_distance_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  jlsd_pkg::jlsd_in_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  jlsd_pkg::jlsd_out_t           out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [jlsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [jlsd_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   result_count_o,
  output int unsigned                   invalid_count_o,
  output int unsigned                   saturated_count_o
);
  import jlsd_pkg::*;

  logic [63:0] decel_q, accel_max_q, jerk_q, latency_q;
  jlsd_out_t   expected_dist_q[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic jlsd_out_t stop_distance(jlsd_in_t req);
    jlsd_out_t    res;
    logic [63:0]  v, acc, react, w, k, dsq, r, s, u, ss, b, ex, div;
    logic [191:0] num, quot, tot;
    v   = 64'(unsigned'(req.speed));
    res = '0;
    if (decel_q == 0 || accel_max_q == 0 || jerk_q == 0 || req.speed[15]) begin
      res.distance = DistMax;
      res.status   = 1'b1;
      return res;
    end
    if (v == 0) return res;
    acc = req.forward_accel[15] ? 64'd0 : 64'(unsigned'(req.forward_accel));
    if (acc > accel_max_q) acc = accel_max_q;
    // everything in fixed units: distance 2^-33 m, speed 2^-20, k 2^-28
    react = ((v * latency_q) << 13) + acc * latency_q * latency_q;
    w     = (v << 12) + acc * latency_q;
    k     = 2 * jerk_q * w + ((acc * acc) << 12);
    dsq   = (decel_q * decel_q) << 12;
    if (k <= dsq) begin
      // vehicle stops inside the braking ramp
      r    = floor_sqrt(k);
      s    = (acc << 6) + r;
      u    = 2 * r - (acc << 6);
      ss   = s * s;
      num  = 192'(ss);
      num  = (num * 192'(u)) << 7;
      div  = 6 * jerk_q * jerk_q;
      quot = num / 192'(div);
    end else begin
      b    = 6 * jerk_q * w + ((2 * acc * acc + acc * decel_q) << 12);
      b    = (b > dsq) ? b - dsq : 64'd0;
      ex   = k - dsq;
      num  = 192'(ex);
      num  = num * 192'(ex) * 192'(6);
      quot = 192'(decel_q * (acc + decel_q));
      quot = (quot * 192'(b)) << 15;
      num  = num + quot;
      div  = 24 * jerk_q * jerk_q * decel_q;
      quot = num / 192'(div);
    end
    tot = quot + 192'(react);
    if (tot >= (192'd1 << 49)) res.distance = DistMax;
    else res.distance = tot[48:25];
    return res;
  endfunction

  assign pending_o = expected_dist_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    jlsd_out_t   want;
    int unsigned errs;
    if (!rst_ni) begin
      decel_q           <= 64'(BrakingDecelRst);
      accel_max_q       <= 64'(MaxAccelRst);
      jerk_q            <= 64'(MaxJerkRst);
      latency_q         <= 64'(ReactionLatencyRst);
      fail_count_o      <= 0;
      result_count_o    <= 0;
      invalid_count_o   <= 0;
      saturated_count_o <= 0;
      expected_dist_q.delete();
    end else begin
      errs = 0;
      if (in_valid_i && !in_stall_i) expected_dist_q.push_back(stop_distance(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        result_count_o <= result_count_o + 1;
        if (out_data_i.status) invalid_count_o <= invalid_count_o + 1;
        else if (out_data_i.distance == DistMax) saturated_count_o <= saturated_count_o + 1;
        if (expected_dist_q.size() == 0) begin
          $error("unexpected result distance=%0h status=%0b",
                 out_data_i.distance, out_data_i.status);
          errs = errs + 1;
        end else begin
          want = expected_dist_q.pop_front();
          if (want.distance !== out_data_i.distance) begin
            $error("distance: expected %0h, got %0h", want.distance, out_data_i.distance);
            errs = errs + 1;
          end
          if (want.status !== out_data_i.status) begin
            $error("status: expected %0b, got %0b", want.status, out_data_i.status);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BRAKING_DECEL:    decel_q     <= 64'(cfg_data_i);
          REG_MAX_ACCEL:        accel_max_q <= 64'(cfg_data_i);
          REG_MAX_JERK:         jerk_q      <= 64'(cfg_data_i);
          REG_REACTION_LATENCY: latency_q   <= 64'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

endmodule

>>> verif/tb_jerk_limited_stopping_distance.sv
`timescale 1ns / 1ps

module tb_jerk_limited_stopping_distance;
  import jlsd_pkg::*;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned NumPhases   = 11;
  localparam int unsigned PhaseItems  = 140;
  localparam logic [CfgIdxW-1:0] RegUnused = 8'd7;

  localparam logic [15:0] DecelSet [NumPhases] = '{16'd1280, 16'd0, 16'd65535, 16'd1, 16'd300,
                                                   16'd2560, 16'd1280, 16'd1280, 16'd700,
                                                   16'd9000, 16'd2000};
  localparam logic [15:0] AccelSet [NumPhases] = '{16'd1280, 16'd500, 16'd65535, 16'd0, 16'd1,
                                                   16'd3000, 16'd1280, 16'd1280, 16'd200,
                                                   16'd40000, 16'd900};
  localparam logic [15:0] JerkSet [NumPhases]  = '{16'd5120, 16'd5120, 16'd1, 16'd65535, 16'd0,
                                                   16'd256, 16'd65535, 16'd5120, 16'd20,
                                                   16'd30000, 16'd3000};
  localparam logic [15:0] LatSet [NumPhases]   = '{16'd410, 16'd0, 16'd65535, 16'd100, 16'd4096,
                                                   16'd0, 16'd65535, 16'd1, 16'd2000,
                                                   16'd32768, 16'd800};

  logic                clk, rst_n;
  logic                in_valid, in_stall, out_valid, out_stall;
  jlsd_in_t            in_data;
  jlsd_out_t           out_data;
  logic                cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                no_idle;
  int unsigned         fails, pending, results, invalids, saturated;
  int unsigned         quiet_cycles;

  jerk_limited_stopping_distance uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  stopping_distance_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fails), .pending_o(pending), .result_count_o(results),
    .invalid_count_o(invalids), .saturated_count_o(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // result side: random stall before each result
  initial begin
    int unsigned w;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      w = idle_cycles();
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_jerk_limited_stopping_distance failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic [15:0] spd, logic [15:0] acc);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {spd, acc};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_request();
    logic [15:0] spd;
    case ($urandom_range(0, 9))
      0:       spd = 16'($urandom);
      1, 2:    spd = 16'($urandom_range(0, 255));
      3:       spd = 16'($urandom_range(0, 15));
      default: spd = 16'($urandom_range(0, 32767));
    endcase
    if ($urandom_range(0, 3) == 0) send_request(spd, 16'($urandom));
    else send_request(spd, 16'($urandom_range(0, 2000)));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed requests at reset settings
    send_request(16'h0000, 16'h0100);
    send_request(16'h0001, 16'h0000);
    send_request(16'h7FFF, 16'h7FFF);
    send_request(16'h7FFF, 16'h8000);
    send_request(16'hFFFF, 16'h0100);
    send_request(16'h8000, 16'h0000);
    send_request(16'h0100, 16'hFF00);
    send_request(16'h0100, 16'h0500);
    send_request(16'h0100, 16'h0600);
    send_request(16'h0010, 16'h0000);
    send_request(16'h0002, 16'h0400);
    send_request(16'h2000, 16'h0200);
    send_request(16'h0A00, 16'h0080);
    send_request(16'h5555, 16'hAAAA);
    send_request(16'h2AAA, 16'h5555);
    drain();
    // unknown index must be ignored
    write_reg(RegUnused, 16'h0000);
    send_request(16'h0300, 16'h0100);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(REG_BRAKING_DECEL, DecelSet[p]);
      write_reg(REG_MAX_ACCEL, AccelSet[p]);
      write_reg(REG_MAX_JERK, JerkSet[p]);
      write_reg(REG_REACTION_LATENCY, LatSet[p]);
      no_idle = (p % 3 == 2);
      send_request(16'h7FFF, 16'h7FFF);
      send_request(16'h0001, 16'h0001);
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2 && p == 5) begin
          // hold off until the pipeline is empty
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        random_request();
      end
    end
    drain();

    $display("requests checked: %0d results, %0d invalid, %0d saturated, %0d settings",
             results, invalids, saturated, NumPhases + 1);
    if (fails == 0) begin
      $display("tb_jerk_limited_stopping_distance passed");
    end else begin
      $display("tb_jerk_limited_stopping_distance failed");
    end
    $finish;
  end

endmodule
